>>> hw/rtl/febm_pkg.sv
// Package for the full/empty bit memory engine.
// Holds the command codes, field widths and the address wrap function.
// No dependencies.
package febm_pkg;

  localparam int WORDS_DEFAULT = 1024;
  localparam int ADDR_IN_W     = 10;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 4'd0,
    CMD_READ_FE  = 4'd1,
    CMD_READ_FF  = 4'd2,
    CMD_WRITE_EF = 4'd3,
    CMD_TRY_EF   = 4'd4,
    CMD_IS_FULL  = 4'd5,
    CMD_FILL     = 4'd6,
    CMD_EMPTY    = 4'd7,
    CMD_ADD      = 4'd8,
    CMD_SUB      = 4'd9,
    CMD_LOCK     = 4'd10,
    CMD_UNLOCK   = 4'd11
  } cmd_t;

  // Reduces an input address modulo the memory depth by compare and subtract
  // of shifted copies of the depth. Only shifts whose multiple still fits in
  // the input range take part, so a larger depth needs fewer steps, and a
  // depth of 1024 or more needs none.
  function automatic logic [ADDR_IN_W-1:0] wrap_address(
    input logic [ADDR_IN_W-1:0] a,
    input int                   words
  );
    logic [ADDR_IN_W-1:0] r;
    longint               m;
    r = a;
    for (int k = ADDR_IN_W - 1; k >= 0; k--) begin
      m = longint'(words) << k;
      if (m < (longint'(1) << ADDR_IN_W)) begin
        if (longint'(r) >= m) begin
          r = r - ADDR_IN_W'(m);
        end
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/febm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module febm_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/full_empty_bit_memory_engine.sv
// Top level of the full/empty bit memory engine.
// Depends on febm_pkg and on the generic RAM febm_ram.
//
// A word memory in which every 32-bit word carries a full/empty bit. A
// command transaction is taken at a rising edge with start high and busy
// low. The word and its bit sit side by side in one synchronous RAM entry:
// the read is issued at the accepting edge, the following cycle modifies the
// entry and writes it back, and the result (status and value) is shown with
// done high for exactly one cycle after that. The receiver cannot stall, so
// the result must be taken in the cycle in which done is high. A command
// occupies the engine for its memory read and then its modify and write
// back through the single RAM port pair; busy is high during the modify
// and write back, so no new command is accepted until it ends. After reset
// the engine sweeps the memory to zero, one entry per cycle, and holds busy
// high until the sweep is done; only then can a command be taken. The
// configuration register lock_when_full is written through its own
// valid/ready channel, which is always ready; it must only be written while
// no command is in flight. Addresses wrap modulo WORDS.
module full_empty_bit_memory_engine #(
  parameter int WORDS = febm_pkg::WORDS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [febm_pkg::CMD_W-1:0]     command,
  input  logic [febm_pkg::ADDR_IN_W-1:0] word_address,
  input  logic [febm_pkg::DATA_W-1:0]    operand,
  output logic                           done,
  output logic                           status,
  output logic [febm_pkg::DATA_W-1:0]    value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  import febm_pkg::*;

  localparam int ADDR_W = $clog2(WORDS);
  localparam int EXT_W  = (ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W;
  localparam int ENTRY_W = DATA_W + 1;

  // The engine is either clearing memory, waiting for a command, or
  // executing the read-modify-write of the command it took.
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic                lock_when_full;

  // Command held from the accepting edge for the execute cycle.
  cmd_t                cmd;
  logic [ADDR_W-1:0]   addr;
  logic [DATA_W-1:0]   opd;

  logic                accept;
  logic [EXT_W-1:0]    wrapped;
  logic [ADDR_W-1:0]   in_idx;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                cur_full;
  logic [DATA_W-1:0]   cur_word;
  cmd_t                eff_cmd;
  logic                new_full;
  logic [DATA_W-1:0]   new_word;
  logic                res_status;
  logic [DATA_W-1:0]   res_value;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // The address is reduced before it reaches the RAM so that the read can
  // start at the accepting edge.
  assign wrapped = EXT_W'(wrap_address(word_address, WORDS));
  assign in_idx  = wrapped[ADDR_W-1:0];

  febm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  assign cur_full = ram_rdata[DATA_W];
  assign cur_word = ram_rdata[DATA_W-1:0];

  // Lock and unlock are mapped onto their plain counterparts by the register.
  always_comb begin
    case (cmd)
      CMD_LOCK:   eff_cmd = lock_when_full ? CMD_READ_FE : CMD_WRITE_EF;
      CMD_UNLOCK: eff_cmd = lock_when_full ? CMD_FILL : CMD_EMPTY;
      default:    eff_cmd = cmd;
    endcase
  end

  // Modify step. A blocked command leaves the entry unchanged and returns
  // status 1 with value 0. Unused codes change nothing and return zeros.
  always_comb begin
    new_full   = cur_full;
    new_word   = cur_word;
    res_status = 1'b0;
    res_value  = '0;
    case (eff_cmd)
      CMD_WRITE: begin
        new_word = opd;
      end
      CMD_READ_FE, CMD_READ_FF: begin
        if (cur_full) begin
          res_value = cur_word;
          if (eff_cmd == CMD_READ_FE) begin
            new_full = 1'b0;
          end
        end else begin
          res_status = 1'b1;
        end
      end
      CMD_WRITE_EF: begin
        if (!cur_full) begin
          new_word = opd;
          new_full = 1'b1;
        end else begin
          res_status = 1'b1;
        end
      end
      CMD_TRY_EF: begin
        if (cur_full) begin
          res_value = DATA_W'(1);
        end else begin
          new_full = 1'b1;
        end
      end
      CMD_IS_FULL: begin
        res_value = DATA_W'(cur_full);
      end
      CMD_FILL: begin
        new_full = 1'b1;
      end
      CMD_EMPTY: begin
        new_full = 1'b0;
      end
      CMD_ADD: begin
        res_value = cur_word;
        new_word  = cur_word + opd;
      end
      CMD_SUB: begin
        res_value = cur_word;
        new_word  = cur_word - opd;
      end
      default: begin
      end
    endcase
  end

  // The clearing sweep and the write-back share the RAM write port; they
  // never overlap because the sweep finishes before any command is taken.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {new_full, new_word};
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_EXEC: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      done           <= 1'b0;
      lock_when_full <= 1'b1;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        lock_when_full <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= cmd_t'(command);
      addr <= in_idx;
      opd  <= operand;
    end
    if (state == S_EXEC) begin
      status <= res_status;
      value  <= res_value;
    end
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted command did not enter execute");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (done && (state == S_IDLE)))
    else $error("execute did not produce a result");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without execute");

  a_blocked_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (value == '0))
    else $error("blocked command returned a nonzero value");
`endif

endmodule
